[design/hpgd_pkg.sv]
package hpgd_pkg;

  typedef enum logic [1:0] {
    MODE_NEUTRAL = 2'd0,
    MODE_FORWARD = 2'd1,
    MODE_REVERSE = 2'd2,
    MODE_BRAKE   = 2'd3
  } mode_e;

  typedef enum logic {
    KIND_DUTY = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef enum logic {
    REG_MAX_DUTY_A = 1'b0,
    REG_MAX_DUTY_B = 1'b1
  } reg_idx_e;

  localparam int unsigned GateW  = 4;
  localparam int unsigned CountW = 8;
  localparam int unsigned DutyW  = 9;

  // Pin order: in1, sd1, in2, sd2
  localparam logic [GateW-1:0] PatNeutral = 4'h0;
  localparam logic [GateW-1:0] PatForward = 4'hD;
  localparam logic [GateW-1:0] PatReverse = 4'h7;
  localparam logic [GateW-1:0] PatBrake   = 4'h5;

  localparam logic [CountW-1:0] MaxDutyReset = 8'd254;

  // Per-channel control shared by both channel units
  typedef struct packed {
    logic              cmd_en;
    logic              tick_en;
    logic              wrap;
    logic [CountW-1:0] count;
  } chan_ctrl_t;

  function automatic logic [GateW-1:0] on_pattern(mode_e mode);
    logic [GateW-1:0] pat;
    case (mode)
      MODE_FORWARD: pat = PatForward;
      MODE_REVERSE: pat = PatReverse;
      MODE_BRAKE:   pat = PatBrake;
      default:      pat = PatNeutral;
    endcase
    return pat;
  endfunction

endpackage

[design/hpgd_chan.sv]
module hpgd_chan (
  input  hpgd_pkg::chan_ctrl_t                  ctrl_i,
  input  logic signed [hpgd_pkg::DutyW-1:0]     duty_i,
  input  logic                                  brake_i,
  input  logic        [hpgd_pkg::CountW-1:0]    max_duty_i,
  input  hpgd_pkg::mode_e                       mode_i,
  input  logic        [hpgd_pkg::CountW-1:0]    compare_i,
  input  logic        [hpgd_pkg::GateW-1:0]     gates_i,
  output hpgd_pkg::mode_e                       mode_o,
  output logic        [hpgd_pkg::CountW-1:0]    compare_o,
  output logic        [hpgd_pkg::GateW-1:0]     gates_o
);
  import hpgd_pkg::*;

  logic             neg;
  logic [DutyW-1:0] mag;
  logic [DutyW-1:0] sat;
  logic [GateW-1:0] off_pat;

  assign neg = duty_i[DutyW-1];
  assign mag = neg ? (~duty_i + 1'b1) : duty_i;
  assign sat = (mag > {1'b0, max_duty_i}) ? {1'b0, max_duty_i} : mag;

  always_comb begin
    case (mode_i)
      MODE_FORWARD, MODE_REVERSE: off_pat = PatBrake;
      MODE_BRAKE: off_pat = (compare_i >= max_duty_i) ? PatBrake : PatNeutral;
      default:    off_pat = PatNeutral;
    endcase
  end

  always_comb begin
    mode_o    = mode_i;
    compare_o = compare_i;
    gates_o   = gates_i;
    if (ctrl_i.cmd_en) begin
      if (duty_i == '0) begin
        mode_o    = MODE_NEUTRAL;
        compare_o = '0;
      end else if (brake_i) begin
        // clamp to 1..255, negative gives 1
        mode_o    = MODE_BRAKE;
        compare_o = neg ? CountW'(1) : duty_i[CountW-1:0];
      end else begin
        // a zero limit leaves the mode alone
        compare_o = sat[CountW-1:0];
        if (sat != '0) begin
          mode_o = neg ? MODE_REVERSE : MODE_FORWARD;
        end
      end
    end else if (ctrl_i.tick_en) begin
      if (ctrl_i.wrap) begin
        gates_o = on_pattern(mode_i);
      end
      if (ctrl_i.count == compare_i) begin
        gates_o = off_pat;
      end
    end
  end

endmodule

[design/hbridge_pwm_gate_driver.sv]
// Two-channel H-bridge PWM gate controller on one shared 8-bit counter. Each
// accepted item (duty command or timer tick) yields exactly one result: both
// channels' gate pins and modes after the update. The update is a single
// compare-and-select pass from the state registers into the result register,
// so a new item is accepted every cycle while the result side is not stalled.
// Duty commands change the mode and compare value at once, the pins only on a
// later tick. Write max_duty_a (index 0) and max_duty_b (index 1) only while
// the block is idle; both reset to 254.
module hbridge_pwm_gate_driver (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic        [hpgd_pkg::CountW-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic                               channel_i,
  input  logic signed [hpgd_pkg::DutyW-1:0]  duty_i,
  input  logic                               brake_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic        [hpgd_pkg::GateW-1:0]  gate_a_o,
  output logic        [hpgd_pkg::GateW-1:0]  gate_b_o,
  output logic        [1:0]                  mode_a_o,
  output logic        [1:0]                  mode_b_o
);
  import hpgd_pkg::*;

  logic              accept;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] max_duty_q [2];
  mode_e             mode_q     [2];
  mode_e             mode_d     [2];
  logic [CountW-1:0] compare_q  [2];
  logic [CountW-1:0] compare_d  [2];
  logic [GateW-1:0]  gates_q    [2];
  logic [GateW-1:0]  gates_d    [2];
  chan_ctrl_t        ctrl       [2];
  logic              out_valid_q;
  logic [GateW-1:0]  gate_a_q, gate_b_q;
  mode_e             mode_a_q, mode_b_q;

  // hold the input while the result register is full and stalled
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign count_d    = count_q + CountW'(1);

  for (genvar c = 0; c < 2; c++) begin : g_chan
    assign ctrl[c].cmd_en  = accept & (kind_i == KIND_DUTY) & (channel_i == 1'(c));
    assign ctrl[c].tick_en = accept & (kind_i == KIND_TICK);
    assign ctrl[c].wrap    = (count_d == '0);
    assign ctrl[c].count   = count_d;

    hpgd_chan u_chan (
      .ctrl_i     (ctrl[c]),
      .duty_i     (duty_i),
      .brake_i    (brake_i),
      .max_duty_i (max_duty_q[c]),
      .mode_i     (mode_q[c]),
      .compare_i  (compare_q[c]),
      .gates_i    (gates_q[c]),
      .mode_o     (mode_d[c]),
      .compare_o  (compare_d[c]),
      .gates_o    (gates_d[c])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mode_q[c]    <= MODE_NEUTRAL;
        compare_q[c] <= '0;
        gates_q[c]   <= PatNeutral;
      end else if (accept) begin
        mode_q[c]    <= mode_d[c];
        compare_q[c] <= compare_d[c];
        gates_q[c]   <= gates_d[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_duty_q[0] <= MaxDutyReset;
      max_duty_q[1] <= MaxDutyReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAX_DUTY_A: max_duty_q[0] <= cfg_data_i;
        REG_MAX_DUTY_B: max_duty_q[1] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept && kind_i == KIND_TICK) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept | in_stall_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      gate_a_q <= gates_d[0];
      gate_b_q <= gates_d[1];
      mode_a_q <= mode_d[0];
      mode_b_q <= mode_d[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign gate_a_o    = gate_a_q;
  assign gate_b_o    = gate_b_q;
  assign mode_a_o    = mode_a_q;
  assign mode_b_o    = mode_b_q;

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("transfer in did not produce a result");

  a_result_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (mode_a_o == mode_q[0]) && (mode_b_o == mode_q[1]) &&
               (gate_a_o == gates_q[0]) && (gate_b_o == gates_q[1]))
    else $error("result register differs from channel state");

  a_cmd_keeps_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == KIND_DUTY) |=>
      (gates_q[0] == $past(gates_q[0])) && (gates_q[1] == $past(gates_q[1])))
    else $error("duty command changed gate pins");

  a_pattern_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gates_q[0] == PatNeutral || gates_q[0] == PatForward ||
     gates_q[0] == PatReverse || gates_q[0] == PatBrake))
    else $error("channel A gate pattern is not a legal pattern");

endmodule
